// File: rtl/bet_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bet_pkg: shared types and codes for the burst event trigger
// Time width, register indexes, mode codes and sequencer states.
// -----------------------------------------------------------------------------
package bet_pkg;

   localparam int TIME_W = 32;
   localparam int CNT_W  = $clog2(TIME_W);
   localparam int IDX_W  = 3;
   localparam int MODE_W = 3;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [TIME_W:0]   wide_time_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // trigger modes
   localparam mode_type MODE_SINGLE      = 3'd0;
   localparam mode_type MODE_TRAIN       = 3'd1;
   localparam mode_type MODE_ONE_BURST   = 3'd2;
   localparam mode_type MODE_BURST_TRAIN = 3'd3;
   localparam mode_type MODE_LIMITED     = 3'd4;

   // register indexes
   localparam idx_type REG_MODE        = 3'd0;
   localparam idx_type REG_START_DELAY = 3'd1;
   localparam idx_type REG_EVENT_IVAL  = 3'd2;
   localparam idx_type REG_BURST_LEN   = 3'd3;
   localparam idx_type REG_BURST_PER   = 3'd4;
   localparam idx_type REG_TRAIN_LEN   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_PHASE,
      ST_GAP,
      ST_SUM,
      ST_LIMIT,
      ST_OUT
   } state_type;

endpackage

// File: rtl/burst_event_trigger.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// burst_event_trigger: event and burst-train trigger on a tick clock
// Fires when the current time reaches the next event time, then plans the
// following event with a shared bit-serial remainder unit.
// -----------------------------------------------------------------------------
//
//   channel   ports                            direction   word
//   req       req_valid/ready, req_now_ticks   in          current time
//   rsp       rsp_valid/ready, rsp_fire,       out         fire and exhausted
//             rsp_exhausted
//   csr       csr_valid/ready, csr_index,      in          register write
//             csr_data
//
// A word that does not fire goes from the check straight to the result register.
// A firing word in modes 1 and 2 makes one pass of the shared restoring
// divider for its remainder (plus the burst end check in mode 2); in modes 3
// and 4 a word may need a second pass of the divider.
// req_ready is high only while the sequencer is idle; a finished result can
// wait in the output register while the next word is taken.
// csr_ready is always high. Reset is synchronous and re-arms the trigger.
//
module burst_event_trigger (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bet_pkg::time_type  req_now_ticks,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fire,
   output logic               rsp_exhausted,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  bet_pkg::idx_type   csr_index,
   input  bet_pkg::time_type  csr_data
);
   import bet_pkg::*;

   state_type     state_ff, state_in;
   mode_type      mode_ff, mode_in;
   time_type      start_ff, start_in;
   time_type      ival_ff, ival_in;
   time_type      blen_ff, blen_in;
   time_type      bper_ff, bper_in;
   time_type      tlen_ff, tlen_in;
   time_type      next_ff, next_in;
   logic          never_ff, never_in;
   time_type      now_ff, now_in;
   time_type      dvd_ff, dvd_in;
   time_type      dsr_ff, dsr_in;
   time_type      rem_ff, rem_in;
   time_type      gap_ff, gap_in;
   wide_time_type limit_ff, limit_in;
   cnt_type       cnt_ff, cnt_in;
   logic          pass2_ff, pass2_in;
   logic          fire_ff, fire_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_fire_ff, rsp_fire_in;
   logic          rsp_exh_ff, rsp_exh_in;

   logic          req_acc, csr_wr, out_free;
   logic          hit, early, use_ival, has_limit, div_last, in_burst, over_limit;
   wide_time_type trial, diff, sum;
   time_type      rem_step;
   mode_type      csr_mode;

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fire      = rsp_fire_ff;
   assign rsp_exhausted = rsp_exh_ff;

   assign req_acc  = req_valid && req_ready;
   assign csr_wr   = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign hit       = !never_ff && (now_ff >= next_ff);
   assign early     = now_ff < start_ff;
   assign use_ival  = (mode_ff == MODE_TRAIN) || (mode_ff == MODE_ONE_BURST);
   assign has_limit = (mode_ff == MODE_ONE_BURST) || (mode_ff == MODE_LIMITED);
   assign div_last  = (cnt_ff == cnt_type'(TIME_W - 1));
   // still inside the burst when phase + interval fits in the burst length
   assign in_burst  = ({1'b0, rem_ff} + {1'b0, ival_ff}) <= {1'b0, blen_ff};
   assign over_limit = {1'b0, next_ff} > limit_ff;
   assign sum       = {1'b0, now_ff} + {1'b0, gap_ff};
   assign csr_mode  = (csr_data[MODE_W-1:0] > MODE_LIMITED) ? MODE_LIMITED
                                                           : csr_data[MODE_W-1:0];

   // one restoring step: remainder stays below the divisor
   assign trial    = {rem_ff, dvd_ff[TIME_W-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign rem_step = diff[TIME_W] ? trial[TIME_W-1:0] : diff[TIME_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!hit || early || (mode_ff == MODE_SINGLE)) state_in = ST_OUT;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = (pass2_ff || use_ival) ? ST_GAP : ST_PHASE;
         end
         ST_PHASE: begin
            state_in = in_burst ? ST_DIV : ST_GAP;
         end
         ST_GAP: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum[TIME_W] || !has_limit) state_in = ST_OUT;
            else state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in      = mode_ff;
      start_in     = start_ff;
      ival_in      = ival_ff;
      blen_in      = blen_ff;
      bper_in      = bper_ff;
      tlen_in      = tlen_ff;
      next_in      = next_ff;
      never_in     = never_ff;
      now_in       = now_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      rem_in       = rem_ff;
      gap_in       = gap_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      pass2_in     = pass2_ff;
      fire_in      = fire_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_fire_in  = rsp_fire_ff;
      rsp_exh_in   = rsp_exh_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) now_in = req_now_ticks;
         end
         ST_CHECK: begin
            fire_in = hit;
            if (hit) begin
               if (early) begin
                  next_in = start_ff;
               end else if (mode_ff == MODE_SINGLE) begin
                  never_in = 1'b1;
               end else begin
                  dvd_in   = now_ff - start_ff;
                  dsr_in   = use_ival ? ival_ff : bper_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  pass2_in = 1'b0;
                  limit_in = {1'b0, start_ff} +
                             {1'b0, (mode_ff == MODE_ONE_BURST) ? blen_ff : tlen_ff};
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
            cnt_in = cnt_ff + cnt_type'(1);
         end
         ST_PHASE: begin
            // phase inside the burst: next event is one interval step away
            if (in_burst) begin
               dvd_in   = rem_ff;
               dsr_in   = ival_ff;
               rem_in   = '0;
               cnt_in   = '0;
               pass2_in = 1'b1;
            end
         end
         ST_GAP: begin
            gap_in = dsr_ff - rem_ff;
         end
         ST_SUM: begin
            if (sum[TIME_W]) never_in = 1'b1;
            else next_in = sum[TIME_W-1:0];
         end
         ST_LIMIT: begin
            if (over_limit) never_in = 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fire_in  = fire_ff;
               rsp_exh_in   = never_ff;
            end
         end
         default: begin
         end
      endcase

      // a write to any defined register (index up to REG_TRAIN_LEN) re-arms the trigger
      if (csr_wr) begin
         case (csr_index)
            REG_MODE:        mode_in  = csr_mode;
            REG_START_DELAY: start_in = csr_data;
            REG_EVENT_IVAL:  ival_in  = (csr_data == '0) ? time_type'(1) : csr_data;
            REG_BURST_LEN:   blen_in  = csr_data;
            REG_BURST_PER:   bper_in  = (csr_data == '0) ? time_type'(1) : csr_data;
            REG_TRAIN_LEN:   tlen_in  = csr_data;
            default: begin
            end
         endcase
         if (csr_index <= REG_TRAIN_LEN) begin
            next_in  = start_in;
            never_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SINGLE;
         start_ff     <= '0;
         ival_ff      <= time_type'(1);
         blen_ff      <= '0;
         bper_ff      <= time_type'(1);
         tlen_ff      <= '0;
         next_ff      <= '0;
         never_ff     <= 1'b0;
         cnt_ff       <= '0;
         pass2_ff     <= 1'b0;
         fire_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         ival_ff      <= ival_in;
         blen_ff      <= blen_in;
         bper_ff      <= bper_in;
         tlen_ff      <= tlen_in;
         next_ff      <= next_in;
         never_ff     <= never_in;
         cnt_ff       <= cnt_in;
         pass2_ff     <= pass2_in;
         fire_ff      <= fire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      rem_ff      <= rem_in;
      gap_ff      <= gap_in;
      limit_ff    <= limit_in;
      rsp_fire_ff <= rsp_fire_in;
      rsp_exh_ff  <= rsp_exh_in;
   end

   // exhausted sticks until a register write re-arms
   a_never_sticky: assert property (@(posedge clock) disable iff (reset)
      (never_ff && !csr_wr) |=> never_ff)
      else $error("exhausted flag cleared without a register write");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");

   a_next_monotonic: assert property (@(posedge clock) disable iff (reset)
      !csr_wr |=> (next_ff >= $past(next_ff)))
      else $error("next event time moved backward");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_CHECK))
      else $error("accepted word did not enter check");

endmodule
